>>> sv/etp_pkg.sv
// ----------------------------------------------------------------------------
// Extent range splitter package
// Item types, operation and status codes, and sizing constants shared by the
// extent table splitter and its checker.
// ----------------------------------------------------------------------------
package etp_pkg;

    localparam int FIELD_W          = 48;
    localparam int MAX_EXTENTS_DEF  = 32;
    localparam int ADDR_BITS_DEF    = 48;
    localparam int RESULT_CAP       = 32;
    localparam int NW               = $clog2(RESULT_CAP + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_HOLE = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [FIELD_W-1:0] logical_start;
        logic [FIELD_W-1:0] physical_start;
        logic [FIELD_W-1:0] span;
        logic               written;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] piece_physical_start;
        logic [FIELD_W-1:0] piece_length;
        logic               unwritten;
        logic [1:0]         status;
        logic               last;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_HOLE
    } t_state;

endpackage

>>> sv/etp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module etp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/extent_range_to_physical_split.sv
// ----------------------------------------------------------------------------
// Extent range to physical split
// A query is accepted, then walks the table one entry at a time (at most
// MAX_EXTENTS entries), and then delivers its final pieces; the single table
// read port and the one per-entry step unit set this pace. Clear and append
// items show their status result in the following cycle. Results appear for
// one cycle under o_strobe and must be taken then, since the block cannot be
// held off; busy stays high while a query is walking.
// ----------------------------------------------------------------------------
module extent_range_to_physical_split
    import etp_pkg::*;
#(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int AW = ADDR_BITS;
    localparam int EW = 3 * AW + 1;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_idx, n_idx;
    logic [NW-1:0]  r_n, n_n;
    logic [AW-1:0]  r_off, n_off;
    logic [AW-1:0]  r_end, n_end;
    logic [AW-1:0]  r_pend_start, n_pend_start;
    logic [AW-1:0]  r_pend_end, n_pend_end;
    logic           r_pend_uw, n_pend_uw;
    logic           r_hole, n_hole;
    logic           r_strobe, n_strobe;
    t_out           r_out, n_out;

    logic [AW+FIELD_W-1:0] w_ls_ext, w_ps_ext, w_sp_ext;
    logic [AW-1:0]         w_ls, w_ps, w_sp;
    logic [AW+FIELD_W-1:0] w_ostart_ext, w_olen_ext;
    logic [AW-1:0]         w_pend_len;
    t_out                  w_pend_out;

    logic                  w_accept;
    logic                  w_wr_en;
    logic [EW-1:0]         w_wr_data;
    logic                  w_rd_en;
    logic [IW-1:0]         w_rd_addr;
    logic [EW-1:0]         w_rd_data;
    logic [CW-1:0]         w_idx_inc;

    logic [AW-1:0] e_ll, e_lr, e_delta;
    logic          e_wr;

    logic          w_live, w_hole, w_skip, w_piece, w_cut;
    logic          w_merge, w_new, w_capped, w_stop, w_uw;
    logic [AW-1:0] w_po, w_pe;
    logic [NW-1:0] w_n_after;
    logic          w_flush_last;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);

    assign w_ls_ext = {{AW{1'b0}}, i_item.logical_start};
    assign w_ps_ext = {{AW{1'b0}}, i_item.physical_start};
    assign w_sp_ext = {{AW{1'b0}}, i_item.span};
    assign w_ls     = w_ls_ext[AW-1:0];
    assign w_ps     = w_ps_ext[AW-1:0];
    assign w_sp     = w_sp_ext[AW-1:0];

    assign w_wr_en   = w_accept && (i_item.op == OP_APPEND) && (r_count < CW'(MAX_EXTENTS));
    assign w_wr_data = {w_ls, w_ls + w_sp, w_ps - w_ls, i_item.written};
    assign w_rd_en   = (r_state == ST_IDLE) || (r_state == ST_WALK);
    assign w_idx_inc = r_idx + CW'(1);
    assign w_rd_addr = ((r_state == ST_WALK) && (w_idx_inc < r_count)) ?
                       w_idx_inc[IW-1:0] : '0;

    etp_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_EXTENTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_count[IW-1:0]),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign {e_ll, e_lr, e_delta, e_wr} = w_rd_data;

    assign w_live    = (r_idx < r_count) && (r_off != r_end);
    assign w_hole    = w_live && (r_off < e_ll);
    assign w_skip    = w_live && !w_hole && (r_off >= e_lr);
    assign w_piece   = w_live && !w_hole && !w_skip;
    assign w_cut     = (r_end >= e_lr);
    assign w_po      = r_off + e_delta;
    assign w_pe      = (w_cut ? e_lr : r_end) + e_delta;
    assign w_uw      = !e_wr;
    assign w_merge   = (r_n != '0) && (w_po == r_pend_end) && (w_uw == r_pend_uw);
    assign w_new     = w_piece && !w_merge && (r_n < NW'(RESULT_CAP));
    assign w_capped  = w_piece && !w_merge && (r_n == NW'(RESULT_CAP));
    assign w_stop    = !w_live || w_hole || w_capped || (w_piece && !w_cut);
    assign w_n_after = r_n + NW'(w_new);
    assign w_flush_last = !(r_hole && (r_n < NW'(RESULT_CAP)));

    assign w_pend_len   = r_pend_end - r_pend_start;
    assign w_ostart_ext = {{FIELD_W{1'b0}}, r_pend_start};
    assign w_olen_ext   = {{FIELD_W{1'b0}}, w_pend_len};

    always_comb begin
        w_pend_out.piece_physical_start = w_ostart_ext[FIELD_W-1:0];
        w_pend_out.piece_length         = w_olen_ext[FIELD_W-1:0];
        w_pend_out.unwritten            = r_pend_uw;
        w_pend_out.status               = STATUS_OK;
        w_pend_out.last                 = 1'b0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_item.op == OP_QUERY)) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_stop) begin
                    n_state = (w_n_after != '0) ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                n_state = w_flush_last ? ST_IDLE : ST_HOLE;
            end
            ST_HOLE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_n          = r_n;
        n_off        = r_off;
        n_end        = r_end;
        n_pend_start = r_pend_start;
        n_pend_end   = r_pend_end;
        n_pend_uw    = r_pend_uw;
        n_hole       = r_hole;
        n_strobe     = 1'b0;
        n_out        = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_off  = w_ls;
                    n_end  = w_ls + w_sp;
                    n_idx  = '0;
                    n_n    = '0;
                    n_hole = 1'b0;
                    if (i_item.op != OP_QUERY) begin
                        n_strobe = 1'b1;
                        n_out    = '0;
                        n_out.last = 1'b1;
                    end
                    if (i_item.op == OP_CLEAR) begin
                        n_count = '0;
                    end else if (i_item.op == OP_APPEND) begin
                        if (w_wr_en) begin
                            n_count = r_count + CW'(1);
                        end else begin
                            n_out.status = STATUS_FULL;
                        end
                    end
                end
            end
            ST_WALK: begin
                n_n    = w_n_after;
                n_hole = w_hole;
                if (w_skip || (w_piece && w_cut && !w_capped)) begin
                    n_idx = w_idx_inc;
                end
                if (w_piece && w_cut && !w_capped) begin
                    n_off = e_lr;
                end
                if (w_piece && w_merge) begin
                    n_pend_end = w_pe;
                end
                if (w_new) begin
                    n_pend_start = w_po;
                    n_pend_end   = w_pe;
                    n_pend_uw    = w_uw;
                    if (r_n != '0) begin
                        n_strobe = 1'b1;
                        n_out    = w_pend_out;
                    end
                end
                if (w_stop && (w_n_after == '0)) begin
                    n_strobe     = 1'b1;
                    n_out        = '0;
                    n_out.status = w_hole ? STATUS_HOLE : STATUS_OK;
                    n_out.last   = 1'b1;
                end
            end
            ST_FLUSH: begin
                n_strobe   = 1'b1;
                n_out      = w_pend_out;
                n_out.last = w_flush_last;
            end
            ST_HOLE: begin
                n_strobe     = 1'b1;
                n_out        = '0;
                n_out.status = STATUS_HOLE;
                n_out.last   = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_idx    <= '0;
            r_n      <= '0;
            r_hole   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_idx    <= n_idx;
            r_n      <= n_n;
            r_hole   <= n_hole;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off        <= n_off;
        r_end        <= n_end;
        r_pend_start <= n_pend_start;
        r_pend_end   <= n_pend_end;
        r_pend_uw    <= n_pend_uw;
        r_out        <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

>>> sv/etp_checker.sv
// ----------------------------------------------------------------------------
// Extent range splitter checker
// Port-level properties of the extent table splitter, bound to the top level.
// ----------------------------------------------------------------------------
module etp_checker
    import etp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_item,
    input logic o_strobe,
    input t_out o_result
);

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.op == OP_QUERY) |=> busy)
        else $error("Accepted query did not raise busy.");

    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.op != OP_QUERY) |=> o_strobe && o_result.last)
        else $error("Clear or append item gave no final result.");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status != STATUS_OK) |->
            o_result.last && (o_result.piece_length == '0) &&
            (o_result.piece_physical_start == '0))
        else $error("Status result is not a final empty result.");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe && o_result.last)
        else $error("Query ended without a final result.");

endmodule

bind extent_range_to_physical_split etp_checker u_etp_checker (.*);
